// File: hdl/owbm_pkg.sv
package owbm_pkg;

  localparam int CFG_WIDTH       = 10;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int TIMER_BITS_DEF  = 10;
  localparam int OPCODE_WIDTH    = 2;
  localparam int BYTE_WIDTH      = 8;
  localparam int BIT_INDEX_WIDTH = 3;

  typedef enum logic [OPCODE_WIDTH-1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_RESET_RECOVER = 3'd2,
    CFG_WRITE_ONE_LOW = 3'd3,
    CFG_SLOT          = 3'd4,
    CFG_READ_LOW      = 3'd5,
    CFG_READ_GAP      = 3'd6,
    CFG_UNUSED        = 3'd7
  } cfg_index_t;

  localparam logic [CFG_WIDTH-1:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [CFG_WIDTH-1:0] PRESENCE_WAIT_DEF = 10'd80;
  localparam logic [CFG_WIDTH-1:0] RESET_RECOVER_DEF = 10'd410;
  localparam logic [CFG_WIDTH-1:0] WRITE_ONE_LOW_DEF = 10'd1;
  localparam logic [CFG_WIDTH-1:0] SLOT_DEF          = 10'd60;
  localparam logic [CFG_WIDTH-1:0] READ_LOW_DEF      = 10'd2;
  localparam logic [CFG_WIDTH-1:0] READ_GAP_DEF      = 10'd60;

endpackage

// File: hdl/owbm_if.sv
interface owbm_cmd_if
  import owbm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [OPCODE_WIDTH-1:0] opcode;
  logic [BYTE_WIDTH-1:0]   data_byte;
  logic                  line_level;

  modport source (output valid, output opcode, output data_byte, output line_level,
                  input ready);
  modport sink   (input valid, input opcode, input data_byte, input line_level,
                  output ready);
endinterface

interface owbm_res_if
  import owbm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  drive_low;
  logic                  busy_res;
  logic                  done_res;
  logic                  device_present;
  logic [BYTE_WIDTH-1:0] read_data;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output device_present, output read_data, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input device_present, input read_data, output ready);
endinterface

// File: hdl/one_wire_bus_master_core.sv
// The result of an accepted request is in the output register in the next cycle.
// Throughput: one request per cycle; a new request is taken only when the output
// register is empty or is being drained in the same cycle.
// A tick or idle-phase command updates phase, timer, shift state in one pass.
// Reset (rst, synchronous, active high) restores default timings, idle phase.
module one_wire_bus_master_core
  import owbm_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  owbm_cmd_if.sink                   cmd,
  owbm_res_if.source                 res
);

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_RST_LOW     = 4'd1,
    PH_RST_WAIT    = 4'd2,
    PH_RST_RELEASE = 4'd3,
    PH_RST_RECOVER = 4'd4,
    PH_W1_LOW      = 4'd5,
    PH_W1_SLOT     = 4'd6,
    PH_W0_LOW      = 4'd7,
    PH_RD_LOW      = 4'd8,
    PH_RD_SAMPLE   = 4'd9,
    PH_RD_GAP      = 4'd10
  } phase_t;

  logic [CFG_WIDTH-1:0] reset_low_time;
  logic [CFG_WIDTH-1:0] presence_wait_time;
  logic [CFG_WIDTH-1:0] reset_recovery_time;
  logic [CFG_WIDTH-1:0] write_one_low_time;
  logic [CFG_WIDTH-1:0] slot_time;
  logic [CFG_WIDTH-1:0] read_low_time;
  logic [CFG_WIDTH-1:0] read_gap_time;

  phase_t                     phase, phase_next;
  logic [TIMER_BITS-1:0]      wait_timer, wait_timer_next;
  logic [BIT_INDEX_WIDTH-1:0] bit_index, bit_index_next;
  logic [BYTE_WIDTH-1:0]      shift_byte, shift_byte_next;
  logic                       presence_flag, presence_flag_next;
  logic [BYTE_WIDTH-1:0]      received_byte, received_byte_next;
  logic                       done;

  logic                       accept;
  logic [TIMER_BITS-1:0]      timer_dec;
  logic                       expired;
  logic [BIT_INDEX_WIDTH-1:0] bit_inc;
  logic                       last_bit;

  logic                       res_valid;
  logic                       drive_low;
  logic                       busy_res;
  logic                       done_res;
  logic [BYTE_WIDTH-1:0]      read_data;

  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign timer_dec = (wait_timer != '0) ? wait_timer - 1'b1 : '0;
  assign expired   = (timer_dec == '0);
  assign bit_inc   = bit_index + 1'b1;
  assign last_bit  = (bit_index == '1);

  always_comb begin
    phase_next         = phase;
    wait_timer_next    = wait_timer;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    received_byte_next = received_byte;
    done               = 1'b0;

    if (opcode_t'(cmd.opcode) != OP_TICK) begin
      if (phase == PH_IDLE) begin
        bit_index_next = '0;
        case (opcode_t'(cmd.opcode))
          OP_RESET: begin
            phase_next      = PH_RST_LOW;
            wait_timer_next = TIMER_BITS'(reset_low_time);
          end
          OP_WRITE: begin
            shift_byte_next = cmd.data_byte;
            if (cmd.data_byte[0]) begin
              phase_next      = PH_W1_LOW;
              wait_timer_next = TIMER_BITS'(write_one_low_time);
            end else begin
              phase_next      = PH_W0_LOW;
              wait_timer_next = TIMER_BITS'(slot_time);
            end
          end
          default: begin
            shift_byte_next = '0;
            phase_next      = PH_RD_LOW;
            wait_timer_next = TIMER_BITS'(read_low_time);
          end
        endcase
      end
    end else begin
      unique case (phase)
        PH_IDLE: ;
        PH_RST_LOW: begin
          wait_timer_next = timer_dec;
          if (expired) begin
            phase_next      = PH_RST_WAIT;
            wait_timer_next = TIMER_BITS'(presence_wait_time);
          end
        end
        PH_RST_WAIT: begin
          wait_timer_next = timer_dec;
          if (expired) begin
            presence_flag_next = !cmd.line_level;
            if (cmd.line_level) begin
              phase_next      = PH_RST_RECOVER;
              wait_timer_next = TIMER_BITS'(reset_recovery_time);
            end else begin
              phase_next = PH_RST_RELEASE;
            end
          end
        end
        PH_RST_RELEASE: begin
          if (cmd.line_level) begin
            phase_next      = PH_RST_RECOVER;
            wait_timer_next = TIMER_BITS'(reset_recovery_time);
          end
        end
        PH_RST_RECOVER: begin
          wait_timer_next = timer_dec;
          if (expired) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        end
        PH_W1_LOW: begin
          wait_timer_next = timer_dec;
          if (expired) begin
            phase_next      = PH_W1_SLOT;
            wait_timer_next = TIMER_BITS'(slot_time);
          end
        end
        PH_W1_SLOT, PH_W0_LOW: begin
          wait_timer_next = timer_dec;
          if (expired) begin
            if (last_bit) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end else begin
              bit_index_next = bit_inc;
              if (shift_byte[bit_inc]) begin
                phase_next      = PH_W1_LOW;
                wait_timer_next = TIMER_BITS'(write_one_low_time);
              end else begin
                phase_next      = PH_W0_LOW;
                wait_timer_next = TIMER_BITS'(slot_time);
              end
            end
          end
        end
        PH_RD_LOW: begin
          wait_timer_next = timer_dec;
          if (expired) begin
            phase_next = PH_RD_SAMPLE;
          end
        end
        PH_RD_SAMPLE: begin
          shift_byte_next             = shift_byte;
          shift_byte_next[bit_index]  = shift_byte[bit_index] | cmd.line_level;
          phase_next                  = PH_RD_GAP;
          wait_timer_next             = TIMER_BITS'(read_gap_time);
        end
        PH_RD_GAP: begin
          wait_timer_next = timer_dec;
          if (expired) begin
            if (last_bit) begin
              received_byte_next = shift_byte;
              phase_next         = PH_IDLE;
              done               = 1'b1;
            end else begin
              bit_index_next  = bit_inc;
              phase_next      = PH_RD_LOW;
              wait_timer_next = TIMER_BITS'(read_low_time);
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_time      <= RESET_LOW_DEF;
      presence_wait_time  <= PRESENCE_WAIT_DEF;
      reset_recovery_time <= RESET_RECOVER_DEF;
      write_one_low_time  <= WRITE_ONE_LOW_DEF;
      slot_time           <= SLOT_DEF;
      read_low_time       <= READ_LOW_DEF;
      read_gap_time       <= READ_GAP_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RESET_LOW:     reset_low_time      <= cfg_data;
        CFG_PRESENCE_WAIT: presence_wait_time  <= cfg_data;
        CFG_RESET_RECOVER: reset_recovery_time <= cfg_data;
        CFG_WRITE_ONE_LOW: write_one_low_time  <= cfg_data;
        CFG_SLOT:          slot_time           <= cfg_data;
        CFG_READ_LOW:      read_low_time       <= cfg_data;
        CFG_READ_GAP:      read_gap_time       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      wait_timer    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      received_byte <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        wait_timer    <= wait_timer_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        presence_flag <= presence_flag_next;
        received_byte <= received_byte_next;
        res_valid     <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      drive_low <= (phase_next == PH_RST_LOW) || (phase_next == PH_W1_LOW) ||
                   (phase_next == PH_W0_LOW)  || (phase_next == PH_RD_LOW);
      busy_res  <= (phase_next != PH_IDLE);
      done_res  <= done;
      read_data <= received_byte_next;
    end
  end

  assign res.valid          = res_valid;
  assign res.drive_low      = drive_low;
  assign res.busy_res       = busy_res;
  assign res.done_res       = done_res;
  assign res.device_present = presence_flag;
  assign res.read_data      = read_data;

endmodule

// File: hdl/owbm_checker.sv
module owbm_checker
  import owbm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_valid,
  input logic                  cmd_ready,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic                  drive_low,
  input logic                  busy_res,
  input logic                  done_res,
  input logic [BYTE_WIDTH-1:0] read_data
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(read_data) && $stable(done_res))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> res_valid)
    else $error("accepted request produced no result");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res && !drive_low)
    else $error("done while still busy");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && drive_low |-> busy_res)
    else $error("bus driven while idle");

endmodule

bind one_wire_bus_master_core owbm_checker u_owbm_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .drive_low (res.drive_low),
  .busy_res  (res.busy_res),
  .done_res  (res.done_res),
  .read_data (res.read_data)
);
